// ----- sv/hes_pkg.sv -----
// Shared constants, types and helpers for the explicit heat stencil block.
package hes_pkg;

  localparam int POINTS     = 64;
  localparam int TEMP_WIDTH = 32;
  localparam int IDX_W      = $clog2(POINTS);
  localparam int STEP_W     = 20;
  localparam int IO_W       = 32;

  typedef logic signed [TEMP_WIDTH-1:0] temp_t;
  typedef logic signed [IO_W-1:0]       io_temp_t;
  typedef logic [STEP_W-1:0]            step_t;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_STEP_COUNT     = 2'd0,
    REG_LEFT_BOUNDARY  = 2'd1,
    REG_RIGHT_BOUNDARY = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_RUN  = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic force_ends;
    logic step;
    logic run_done;
  } hes_ctrl_t;

  function automatic temp_t to_temp(input io_temp_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[TEMP_WIDTH-1:0];
  endfunction

  function automatic io_temp_t from_temp(input temp_t t);
    logic signed [63:0] w;
    w = 64'(t);
    return w[IO_W-1:0];
  endfunction

  // floor((2*t + l + r) / 4) without widening the datapath
  function automatic temp_t relax(input temp_t t, input temp_t l, input temp_t r);
    logic [3:0] low_sum;
    temp_t      hi;
    low_sum = {2'b00, t[0], 1'b0} + {2'b00, l[1:0]} + {2'b00, r[1:0]};
    hi      = (t >>> 1) + (l >>> 2) + (r >>> 2);
    return hi + temp_t'({2'b00, low_sum[3:2]});
  endfunction

endpackage

// ----- sv/hes_cell.sv -----
// One grid point of the stencil row: load, boundary force and relaxation update.
module hes_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_en,
  input  hes_pkg::temp_t load_value,
  input  logic          force_en,
  input  hes_pkg::temp_t force_value,
  input  logic          step_en,
  input  hes_pkg::temp_t left,
  input  hes_pkg::temp_t right,
  output hes_pkg::temp_t temp
);
  import hes_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp <= '0;
    end else if (load_en) begin
      temp <= load_value;
    end else if (force_en) begin
      temp <= force_value;
    end else if (step_en) begin
      temp <= relax(temp, left, right);
    end
  end

endmodule

// ----- sv/hes_ctrl.sv -----
// Run sequencer: forces the end points, counts time steps and flags completion.
module hes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              run_start,
  input  hes_pkg::step_t    step_count,
  output logic              busy,
  output hes_pkg::hes_ctrl_t ctrl
);
  import hes_pkg::*;

  state_t state;
  state_t state_next;
  step_t  steps_remaining;
  step_t  steps_remaining_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      steps_remaining <= '0;
    end else begin
      state           <= state_next;
      steps_remaining <= steps_remaining_next;
    end
  end

  always_comb begin
    state_next           = state;
    steps_remaining_next = steps_remaining;
    ctrl                 = '0;
    busy                 = 1'b0;
    case (state)
      ST_IDLE: begin
        if (run_start) begin
          ctrl.force_ends      = 1'b1;
          steps_remaining_next = step_count;
          state_next           = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b1;
        if (steps_remaining == '0) begin
          ctrl.run_done = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          ctrl.step            = 1'b1;
          steps_remaining_next = steps_remaining - step_t'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_start_enters_run: assert property (@(posedge clk) disable iff (rst)
    ctrl.force_ends |=> (busy && steps_remaining == $past(step_count)))
    else $error("run start did not load the step counter");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |=> (steps_remaining == $past(steps_remaining) - step_t'(1)))
    else $error("step counter did not advance");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    ctrl.run_done |=> (!busy && steps_remaining == '0))
    else $error("run did not finish cleanly");

  a_no_step_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!ctrl.step && !ctrl.run_done))
    else $error("update or done outside a run");

endmodule

// ----- sv/heat_explicit_stencil.sv -----
// Top level of the explicit 1D heat stencil: register file, cell row and result beat.
// A load gives no result. A read gives its result beat on the cycle after start. A run
// holds busy high while the row of cells performs step_count full time steps, one per cycle,
// all interior points in parallel, and while the run closes; the completion beat appears
// in the cycle in which busy drops. Every result beat lasts exactly one cycle and
// cannot be held off by the receiver.
module heat_explicit_stencil (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic [9:0]          point_index,
  input  hes_pkg::io_temp_t   temperature_in,
  output hes_pkg::io_temp_t   temperature_out,
  output logic                result_kind,
  output logic                result_valid,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import hes_pkg::*;

  step_t     step_count;
  io_temp_t  left_boundary;
  io_temp_t  right_boundary;
  hes_ctrl_t ctrl;
  temp_t     temps [POINTS];
  logic      accept;
  logic      in_range;
  logic      load_accept;
  logic      read_accept;
  logic      run_start;
  io_temp_t  read_value;

  assign accept      = start && !busy;
  assign in_range    = {1'b0, point_index} < 11'(POINTS);
  assign load_accept = accept && (command == CMD_LOAD) && in_range;
  assign read_accept = accept && (command == CMD_READ);
  assign run_start   = accept && (command == CMD_RUN);
  assign read_value  = in_range ? from_temp(temps[point_index[IDX_W-1:0]]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count     <= '0;
      left_boundary  <= '0;
      right_boundary <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_COUNT:     step_count     <= cfg_data[STEP_W-1:0];
        REG_LEFT_BOUNDARY:  left_boundary  <= cfg_data;
        REG_RIGHT_BOUNDARY: right_boundary <= cfg_data;
        default: ;
      endcase
    end
  end

  hes_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .run_start  (run_start),
    .step_count (step_count),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    logic  load_en;
    logic  force_en;
    logic  step_en;
    temp_t force_value;
    temp_t left;
    temp_t right;

    assign load_en = load_accept && (point_index[IDX_W-1:0] == IDX_W'(i));

    if (i == 0) begin : g_left_end
      assign force_en    = ctrl.force_ends;
      assign force_value = to_temp(left_boundary);
      assign step_en     = 1'b0;
      assign left        = temps[i];
      assign right       = temps[i+1];
    end else if (i == POINTS - 1) begin : g_right_end
      assign force_en    = ctrl.force_ends;
      assign force_value = to_temp(right_boundary);
      assign step_en     = 1'b0;
      assign left        = temps[i-1];
      assign right       = temps[i];
    end else begin : g_interior
      assign force_en    = 1'b0;
      assign force_value = '0;
      assign step_en     = ctrl.step;
      assign left        = temps[i-1];
      assign right       = temps[i+1];
    end

    hes_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .load_en     (load_en),
      .load_value  (to_temp(temperature_in)),
      .force_en    (force_en),
      .force_value (force_value),
      .step_en     (step_en),
      .left        (left),
      .right       (right),
      .temp        (temps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= read_accept || ctrl.run_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.run_done) begin
      temperature_out <= '0;
      result_kind     <= KIND_RUN;
    end else if (read_accept) begin
      temperature_out <= read_value;
      result_kind     <= KIND_READ;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the explicit 1D heat stencil: directed table, then random phases.
module testbench;
  import hes_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int GAP_MAX = 11;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 140;
  localparam logic [31:0] STEPS_FULL = 32'h000F_FFFF;
  localparam io_temp_t TEMP_MAX = 32'sh7FFF_FFFF;
  localparam io_temp_t TEMP_MIN = 32'sh8000_0000;

  typedef struct packed {
    io_temp_t temp;
    kind_t    kind;
  } beat_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_sel;
    logic [31:0] reg_val;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    io_temp_t    temp;
    bit          typed;
    beat_t       want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_LOAD;
  logic [9:0]  point_index = '0;
  io_temp_t    temperature_in = '0;
  io_temp_t    temperature_out;
  logic        result_kind;
  logic        result_valid;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_STEP_COUNT;
  logic [31:0] cfg_data = '0;

  temp_t    heat_grid [POINTS];
  step_t    step_cfg;
  io_temp_t left_cfg;
  io_temp_t right_cfg;
  beat_t    pending_beats [$];
  bit       calm;
  int       errors;
  int       n_items, n_loads, n_reads, n_runs, n_beats, n_settings;

  heat_explicit_stencil i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .point_index    (point_index),
    .temperature_in (temperature_in),
    .temperature_out(temperature_out),
    .result_kind    (result_kind),
    .result_valid   (result_valid),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && result_valid) begin
      n_beats++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: temperature_out %0d result_kind %0d",
               temperature_out, result_kind);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (temperature_out !== want.temp) begin
          $error("temperature_out expected %0d actual %0d", want.temp, temperature_out);
          errors++;
        end
        if (result_kind !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, result_kind);
          errors++;
        end
      end
    end
  end

  // floor((2*t + l + r) / 4) on a datapath wide enough never to wrap
  function automatic temp_t diffuse(temp_t t, temp_t l, temp_t r);
    logic signed [TEMP_WIDTH+2:0] sum;
    sum = (TEMP_WIDTH+3)'(t);
    sum = (sum <<< 1) + (TEMP_WIDTH+3)'(l) + (TEMP_WIDTH+3)'(r);
    return temp_t'(sum >>> 2);
  endfunction

  function automatic void run_heat();
    temp_t prev [POINTS];
    bit    moved;
    heat_grid[0]        = temp_t'(left_cfg);
    heat_grid[POINTS-1] = temp_t'(right_cfg);
    for (int s = 0; s < step_cfg; s++) begin
      prev  = heat_grid;
      moved = 1'b0;
      for (int i = 1; i < POINTS - 1; i++) begin
        heat_grid[i] = diffuse(prev[i], prev[i-1], prev[i+1]);
        if (heat_grid[i] != prev[i]) moved = 1'b1;
      end
      // stop once the profile is steady
      if (!moved) break;
    end
  endfunction

  function automatic void predict(logic [1:0] cmd, logic [9:0] idx, io_temp_t temp,
                                  bit typed, beat_t want);
    beat_t got;
    n_items++;
    case (cmd)
      CMD_LOAD: begin
        n_loads++;
        if (idx < POINTS) heat_grid[idx[IDX_W-1:0]] = temp_t'(temp);
      end
      CMD_RUN: begin
        n_runs++;
        run_heat();
        got.temp = '0;
        got.kind = KIND_RUN;
        pending_beats.push_back(typed ? want : got);
      end
      CMD_READ: begin
        n_reads++;
        got.temp = (idx < POINTS) ? io_temp_t'(heat_grid[idx[IDX_W-1:0]]) : '0;
        got.kind = KIND_READ;
        pending_beats.push_back(typed ? want : got);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [9:0] idx, io_temp_t temp, int gap,
                           bit typed, beat_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    command        <= cmd;
    point_index    <= idx;
    temperature_in <= temp;
    do @(posedge clk); while (busy);
    predict(cmd, idx, temp, typed, want);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] sel, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_STEP_COUNT:     step_cfg  = val[STEP_W-1:0];
      REG_LEFT_BOUNDARY:  left_cfg  = val;
      REG_RIGHT_BOUNDARY: right_cfg = val;
      default: ;
    endcase
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic io_temp_t pick_temp();
    case ($urandom_range(0, 7))
      0: return TEMP_MAX;
      1: return TEMP_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [9:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(POINTS, 1023));
    return 10'($urandom_range(0, POINTS - 1));
  endfunction

  function automatic logic [31:0] pick_steps();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return $urandom_range(100, 600);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic row_t cmd_row(logic [1:0] cmd, logic [9:0] idx, io_temp_t temp,
                                   bit typed, io_temp_t want_temp, kind_t want_kind);
    row_t r;
    r.is_cfg    = 1'b0;
    r.reg_sel   = REG_STEP_COUNT;
    r.reg_val   = '0;
    r.cmd       = cmd;
    r.idx       = idx;
    r.temp      = temp;
    r.typed     = typed;
    r.want.temp = want_temp;
    r.want.kind = want_kind;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] sel, logic [31:0] val);
    row_t r;
    r         = cmd_row(CMD_LOAD, '0, '0, 1'b0, '0, KIND_READ);
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    row_t       rows [$];
    int         roll;
    logic [1:0] cmd;
    logic [9:0] idx;

    foreach (heat_grid[i]) heat_grid[i] = '0;
    step_cfg  = '0;
    left_cfg  = '0;
    right_cfg = '0;

    rows.push_back(cmd_row(CMD_READ, 10'd0, '0, 1'b1, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'(POINTS - 1), '0, 1'b1, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd1023, '1, 1'b1, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_LOAD, 10'd5, TEMP_MAX, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_LOAD, 10'd6, TEMP_MIN, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_LOAD, 10'd1023, 32'sh1234_5678, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_LOAD, 10'(POINTS), '1, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_SPARE, 10'd5, '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd5, '0, 1'b1, TEMP_MAX, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd6, '0, 1'b1, TEMP_MIN, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'(POINTS), '0, 1'b1, '0, KIND_READ));
    rows.push_back(cfg_row(REG_SPARE, '1));
    rows.push_back(cfg_row(REG_STEP_COUNT, '0));
    rows.push_back(cfg_row(REG_LEFT_BOUNDARY, TEMP_MAX));
    rows.push_back(cfg_row(REG_RIGHT_BOUNDARY, TEMP_MIN));
    rows.push_back(cmd_row(CMD_RUN, 10'd0, '0, 1'b1, '0, KIND_RUN));
    rows.push_back(cmd_row(CMD_READ, 10'd0, '0, 1'b1, TEMP_MAX, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'(POINTS - 1), '0, 1'b1, TEMP_MIN, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd5, '0, 1'b1, TEMP_MAX, KIND_READ));
    rows.push_back(cfg_row(REG_STEP_COUNT, 32'd1));
    rows.push_back(cmd_row(CMD_RUN, 10'd0, '0, 1'b1, '0, KIND_RUN));
    rows.push_back(cmd_row(CMD_READ, 10'd4, '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd5, '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'd6, '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_LOAD, 10'(POINTS - 2), '1, 1'b0, '0, KIND_READ));
    rows.push_back(cfg_row(REG_STEP_COUNT, STEPS_FULL));
    rows.push_back(cmd_row(CMD_RUN, 10'd0, '0, 1'b1, '0, KIND_RUN));
    rows.push_back(cmd_row(CMD_READ, 10'd1, '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'(POINTS / 2), '0, 1'b0, '0, KIND_READ));
    rows.push_back(cmd_row(CMD_READ, 10'(POINTS - 2), '0, 1'b0, '0, KIND_READ));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[n]) begin
      if (rows[n].is_cfg) begin
        settle();
        write_reg(rows[n].reg_sel, rows[n].reg_val);
      end else begin
        send_item(rows[n].cmd, rows[n].idx, rows[n].temp, $urandom_range(0, GAP_MAX),
                  rows[n].typed, rows[n].want);
      end
    end
    n_settings = 3;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_STEP_COUNT, pick_steps());
      write_reg(REG_LEFT_BOUNDARY, pick_temp());
      write_reg(REG_RIGHT_BOUNDARY, pick_temp());
      if (p % 4 == 3) write_reg(REG_SPARE, $urandom());
      n_settings++;
      calm = (p % 3 == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // on one item in fifty, hold off until the block has drained
        if ($urandom_range(0, 49) == 0) settle();
        roll = $urandom_range(0, 99);
        if (roll < 45) cmd = CMD_LOAD;
        else if (roll < 82) cmd = CMD_READ;
        else if (roll < 94) cmd = CMD_RUN;
        else cmd = CMD_SPARE;
        idx = pick_index();
        send_item(cmd, idx, pick_temp(), draw_gap(), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d commands: %0d loads, %0d reads, %0d runs, %0d result beats.",
             n_items, n_loads, n_reads, n_runs, n_beats);
    $display("Register settings exercised: %0d, step counts from zero to full scale.",
             n_settings);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hes_pkg.sv
sv/hes_cell.sv
sv/hes_ctrl.sv
sv/heat_explicit_stencil.sv
tb/testbench.sv
